[hw/rtl/bpc_pkg.sv]
// bpc_pkg: types and constants shared by the button press classifier
// modes, configuration register indexes, item, result and settings structs
// no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TimeW   = 32;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [TimeW-1:0]   ms_t;

  localparam cfg_idx_t CFG_ACTIVE_LOW   = 3'd0;
  localparam cfg_idx_t CFG_DEBOUNCE_MS  = 3'd1;
  localparam cfg_idx_t CFG_HOLD_MS      = 3'd2;
  localparam cfg_idx_t CFG_LONG_HOLD_MS = 3'd3;
  localparam cfg_idx_t CFG_IDLE_MS      = 3'd4;

  localparam ms_t RST_DEBOUNCE_MS  = 32'd50;
  localparam ms_t RST_HOLD_MS      = 32'd500;
  localparam ms_t RST_LONG_HOLD_MS = 32'd2000;
  localparam ms_t RST_IDLE_MS      = 32'd10000;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PRECLICK = 3'd1,
    MODE_CLICK    = 3'd2,
    MODE_HOLD     = 3'd3,
    MODE_LONGHOLD = 3'd4,
    MODE_FORCED   = 3'd5
  } mode_t;

  typedef struct packed {
    logic active_low;
    ms_t  debounce_ms;
    ms_t  hold_ms;
    ms_t  long_hold_ms;
    ms_t  idle_ms;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    ms_t  now_ms;
  } item_t;

  typedef struct packed {
    mode_t button_mode;
    logic  click_began;
    logic  hold_began;
    logic  long_hold_began;
    logic  click_ended;
    logic  hold_ended;
    logic  long_hold_ended;
    logic  forced_idle_ended;
  } result_t;

  typedef struct packed {
    mode_t mode;
    ms_t   press_time;
  } press_state_t;

endpackage

[hw/rtl/bpc_in_if.sv]
// bpc_in_if: poll channel, valid/ready handshake with pin level and time
// no dependencies
`timescale 1ns / 1ps

interface bpc_in_if;
  logic            valid;
  logic            ready;
  logic            pin_level;
  logic [31:0]     now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

[hw/rtl/bpc_out_if.sv]
// bpc_out_if: result channel, valid/ready handshake with mode and event pulses
// no dependencies
`timescale 1ns / 1ps

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] button_mode;
  logic       click_began;
  logic       hold_began;
  logic       long_hold_began;
  logic       click_ended;
  logic       hold_ended;
  logic       long_hold_ended;
  logic       forced_idle_ended;

  modport source (
    output valid, output button_mode, output click_began, output hold_began,
    output long_hold_began, output click_ended, output hold_ended,
    output long_hold_ended, output forced_idle_ended, input ready
  );
  modport sink (
    input valid, input button_mode, input click_began, input hold_began,
    input long_hold_began, input click_ended, input hold_ended,
    input long_hold_ended, input forced_idle_ended, output ready
  );
endinterface

[hw/rtl/bpc_cfg_if.sv]
// bpc_cfg_if: configuration write channel, register index and write data
// no dependencies
`timescale 1ns / 1ps

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bpc_step.sv]
// bpc_step: combinational press/release, debounce, hold, long-hold and idle rules
// depends on bpc_pkg
`timescale 1ns / 1ps

module bpc_step (
  input  bpc_pkg::cfg_t         cfg,
  input  bpc_pkg::item_t        item,
  input  bpc_pkg::press_state_t state_cur,
  output bpc_pkg::press_state_t state_nxt,
  output bpc_pkg::result_t      result
);
  import bpc_pkg::*;

  logic  pressed;
  mode_t mode_a;
  ms_t   time_a;
  ms_t   elapsed;
  mode_t mode_b;
  mode_t mode_c;
  mode_t mode_d;
  mode_t mode_e;

  always_comb begin
    pressed = cfg.active_low ? ~item.pin_level : item.pin_level;
    result  = '0;
    mode_a  = state_cur.mode;
    time_a  = state_cur.press_time;

    if (pressed) begin
      if (state_cur.mode == MODE_IDLE) begin
        mode_a = MODE_PRECLICK;
        time_a = item.now_ms;
      end
    end else begin
      mode_a = MODE_IDLE;
      unique case (state_cur.mode)
        MODE_CLICK:    result.click_ended       = 1'b1;
        MODE_HOLD:     result.hold_ended        = 1'b1;
        MODE_LONGHOLD: result.long_hold_ended   = 1'b1;
        MODE_FORCED:   result.forced_idle_ended = 1'b1;
        default: ;
      endcase
    end

    // wrapping difference, rules chained so one poll may advance several modes
    elapsed = item.now_ms - time_a;

    mode_b = mode_a;
    if (elapsed > cfg.debounce_ms && mode_a == MODE_PRECLICK) begin
      mode_b = MODE_CLICK;
      result.click_began = 1'b1;
    end
    mode_c = mode_b;
    if (elapsed > cfg.hold_ms && mode_b == MODE_CLICK) begin
      mode_c = MODE_HOLD;
      result.hold_began = 1'b1;
    end
    mode_d = mode_c;
    if (elapsed > cfg.long_hold_ms && mode_c == MODE_HOLD) begin
      mode_d = MODE_LONGHOLD;
      result.long_hold_began = 1'b1;
    end
    mode_e = mode_d;
    if (elapsed > cfg.idle_ms && mode_d == MODE_LONGHOLD) begin
      mode_e = MODE_FORCED;
    end

    result.button_mode   = mode_e;
    state_nxt.mode       = mode_e;
    state_nxt.press_time = time_a;
  end

endmodule

[hw/rtl/bpc_cfg_regs.sv]
// bpc_cfg_regs: configuration registers written over the cfg channel
// depends on bpc_pkg and bpc_cfg_if
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  bpc_cfg_if.sink        cfg_chan,
  output bpc_pkg::cfg_t  cfg
);
  import bpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_ACTIVE_LOW:   cfg_nxt.active_low   = cfg_chan.data[0];
        CFG_DEBOUNCE_MS:  cfg_nxt.debounce_ms  = cfg_chan.data;
        CFG_HOLD_MS:      cfg_nxt.hold_ms      = cfg_chan.data;
        CFG_LONG_HOLD_MS: cfg_nxt.long_hold_ms = cfg_chan.data;
        CFG_IDLE_MS:      cfg_nxt.idle_ms      = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low   <= 1'b1;
      cfg_r.debounce_ms  <= RST_DEBOUNCE_MS;
      cfg_r.hold_ms      <= RST_HOLD_MS;
      cfg_r.long_hold_ms <= RST_LONG_HOLD_MS;
      cfg_r.idle_ms      <= RST_IDLE_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hw/rtl/bpc_datapath.sv]
// bpc_datapath: input register, press state, result register and handshakes
// depends on bpc_pkg, bpc_in_if, bpc_out_if and bpc_step
`timescale 1ns / 1ps

module bpc_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  bpc_pkg::cfg_t cfg,
  bpc_in_if.sink        in_chan,
  bpc_out_if.source     out_chan
);
  import bpc_pkg::*;

  logic         s1_valid_r;
  item_t        s1_item_r;
  press_state_t state_r;
  press_state_t state_nxt;
  logic         out_valid_r;
  result_t      out_res_r;
  result_t      res_nxt;
  logic         out_free;
  logic         s1_move;
  logic         in_beat;

  // result slot frees when empty or taken this cycle
  assign out_free      = ~out_valid_r | out_chan.ready;
  assign s1_move       = s1_valid_r & out_free;
  assign in_chan.ready = ~s1_valid_r | s1_move;
  assign in_beat       = in_chan.valid & in_chan.ready;

  bpc_step u_step (
    .cfg       (cfg),
    .item      (s1_item_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      state_r.mode       <= MODE_IDLE;
      state_r.press_time <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item_r.pin_level <= in_chan.pin_level;
      s1_item_r.now_ms    <= in_chan.now_ms;
    end
    if (s1_move) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.button_mode       = out_res_r.button_mode;
  assign out_chan.click_began       = out_res_r.click_began;
  assign out_chan.hold_began        = out_res_r.hold_began;
  assign out_chan.long_hold_began   = out_res_r.long_hold_began;
  assign out_chan.click_ended       = out_res_r.click_ended;
  assign out_chan.hold_ended        = out_res_r.hold_ended;
  assign out_chan.long_hold_ended   = out_res_r.long_hold_ended;
  assign out_chan.forced_idle_ended = out_res_r.forced_idle_ended;

endmodule

[hw/rtl/button_press_classifier.sv]
// button_press_classifier: an accepted poll beat goes through the input register and
// the result register to its result beat on the output; throughput one poll per cycle
// while the output is not stalled, set by the press state update between them.
// synchronous active-low reset: mode idle, press time zero, settings to their
// defaults (active low, 50 / 500 / 2000 / 10000 ms), both pipeline slots empty.
`timescale 1ns / 1ps

module button_press_classifier (
  input  logic      clk,
  input  logic      rst_n,
  bpc_in_if.sink    in_chan,
  bpc_out_if.source out_chan,
  bpc_cfg_if.sink   cfg_chan
);
  import bpc_pkg::*;

  cfg_t cfg;

  bpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  bpc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

[sim/testbench.sv]
// testbench for button_press_classifier: directed gestures, threshold extremes,
// back-pressure and random gesture traffic checked against an in-bench predictor
// depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg_if and the rtl top
`timescale 1ns / 1ps

module testbench;
  import bpc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();
  bpc_cfg_if cfg_if ();

  button_press_classifier DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state, mirrors the block's settings and press tracking
  cfg_t         shadow_cfg;
  press_state_t shadow_press;
  result_t      pending_results[$];

  ms_t         clock_ms = '0;
  bit          in_gaps = 1'b1;
  bit          out_gaps = 1'b1;
  int unsigned hold_off_left = 0;
  int unsigned mismatches = 0;
  int unsigned polls_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned long_holds_begun = 0;
  int unsigned forced_releases = 0;

  function automatic result_t classify_poll(input logic pin, input ms_t now);
    result_t r;
    logic    pressed;
    ms_t     elapsed;
    r = '0;
    pressed = shadow_cfg.active_low ? !pin : pin;
    if (pressed) begin
      if (shadow_press.mode == MODE_IDLE) begin
        shadow_press.press_time = now;
        shadow_press.mode = MODE_PRECLICK;
      end
    end else begin
      case (shadow_press.mode)
        MODE_CLICK:    r.click_ended = 1'b1;
        MODE_HOLD:     r.hold_ended = 1'b1;
        MODE_LONGHOLD: r.long_hold_ended = 1'b1;
        MODE_FORCED:   r.forced_idle_ended = 1'b1;
        default: ;
      endcase
      shadow_press.mode = MODE_IDLE;
    end
    // wrapping difference, rules chained so one poll can climb several modes
    elapsed = now - shadow_press.press_time;
    if (elapsed > shadow_cfg.debounce_ms && shadow_press.mode == MODE_PRECLICK) begin
      shadow_press.mode = MODE_CLICK;
      r.click_began = 1'b1;
    end
    if (elapsed > shadow_cfg.hold_ms && shadow_press.mode == MODE_CLICK) begin
      shadow_press.mode = MODE_HOLD;
      r.hold_began = 1'b1;
    end
    if (elapsed > shadow_cfg.long_hold_ms && shadow_press.mode == MODE_HOLD) begin
      shadow_press.mode = MODE_LONGHOLD;
      r.long_hold_began = 1'b1;
    end
    if (elapsed > shadow_cfg.idle_ms && shadow_press.mode == MODE_LONGHOLD) begin
      shadow_press.mode = MODE_FORCED;
    end
    r.button_mode = shadow_press.mode;
    return r;
  endfunction

  // sink side: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(out_gaps && $urandom_range(99) < 36);
    end
  end

  task automatic check_field(input string name, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding, mode %0d", out_if.button_mode);
        mismatches++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        check_field("button_mode", want.button_mode, out_if.button_mode);
        check_bit("click_began", want.click_began, out_if.click_began);
        check_bit("hold_began", want.hold_began, out_if.hold_began);
        check_bit("long_hold_began", want.long_hold_began, out_if.long_hold_began);
        check_bit("click_ended", want.click_ended, out_if.click_ended);
        check_bit("hold_ended", want.hold_ended, out_if.hold_ended);
        check_bit("long_hold_ended", want.long_hold_ended, out_if.long_hold_ended);
        check_bit("forced_idle_ended", want.forced_idle_ended,
                  out_if.forced_idle_ended);
        results_checked++;
      end
    end
  end

  task automatic send_poll(input logic pin, input ms_t now);
    result_t r;
    in_if.valid <= 1'b1;
    in_if.pin_level <= pin;
    in_if.now_ms <= now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = classify_poll(pin, now);
    if (r.long_hold_began) long_holds_begun++;
    if (r.forced_idle_ended) forced_releases++;
    pending_results.push_back(r);
    polls_sent++;
    // each idle cycle is drawn on its own
    while (in_gaps && $urandom_range(99) < 36) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // pipeline is two deep; waits until every outstanding result has been checked
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input ms_t data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_ACTIVE_LOW:   shadow_cfg.active_low = data[0];
      CFG_DEBOUNCE_MS:  shadow_cfg.debounce_ms = data;
      CFG_HOLD_MS:      shadow_cfg.hold_ms = data;
      CFG_LONG_HOLD_MS: shadow_cfg.long_hold_ms = data;
      CFG_IDLE_MS:      shadow_cfg.idle_ms = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    ms_t junk;
    drain_results();
    // unused index first, must leave every setting alone
    write_reg(cfg_idx_t'($urandom_range(CFG_IDLE_MS + 1, (1 << CfgIdxW) - 1)), $urandom);
    junk = $urandom;
    write_reg(CFG_ACTIVE_LOW, {junk[31:1], s.active_low});
    write_reg(CFG_DEBOUNCE_MS, s.debounce_ms);
    write_reg(CFG_HOLD_MS, s.hold_ms);
    write_reg(CFG_LONG_HOLD_MS, s.long_hold_ms);
    write_reg(CFG_IDLE_MS, s.idle_ms);
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.active_low = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: begin
        s.debounce_ms = $urandom_range(0, 20);
        s.hold_ms = s.debounce_ms + $urandom_range(0, 60);
        s.long_hold_ms = s.hold_ms + $urandom_range(0, 120);
        s.idle_ms = s.long_hold_ms + $urandom_range(0, 200);
      end
      1: begin
        s.debounce_ms = $urandom;
        s.hold_ms = $urandom;
        s.long_hold_ms = $urandom;
        s.idle_ms = $urandom;
      end
      2: begin
        s.debounce_ms = $urandom_range(0, 300);
        s.hold_ms = $urandom_range(0, 300);
        s.long_hold_ms = $urandom_range(0, 300);
        s.idle_ms = $urandom_range(0, 300);
      end
      default: begin
        s.debounce_ms = $urandom_range(1) ? '1 : '0;
        s.hold_ms = $urandom_range(1) ? '1 : '0;
        s.long_hold_ms = $urandom_range(1) ? '1 : '0;
        s.idle_ms = $urandom_range(1) ? '1 : '0;
      end
    endcase
    return s;
  endfunction

  // mostly lands one below, on, or one above a threshold
  function automatic ms_t next_elapsed(input ms_t prev);
    int unsigned pick;
    ms_t         thr;
    pick = $urandom_range(9);
    if (pick >= 9) return ms_t'($urandom);
    if (pick >= 6) return prev + $urandom_range(0, 300);
    case (pick % 4)
      0: thr = shadow_cfg.debounce_ms;
      1: thr = shadow_cfg.hold_ms;
      2: thr = shadow_cfg.long_hold_ms;
      default: thr = shadow_cfg.idle_ms;
    endcase
    return thr + $urandom_range(2) - 1;
  endfunction

  task automatic run_gesture();
    logic        held;
    ms_t         base;
    ms_t         el;
    int unsigned polls;
    held = !shadow_cfg.active_low;
    send_poll(held, ($urandom_range(7) == 0) ? ms_t'($urandom)
                                             : clock_ms + $urandom_range(0, 50));
    base = shadow_press.press_time;
    el = '0;
    polls = $urandom_range(0, 8);
    repeat (polls) begin
      el = next_elapsed(el);
      send_poll(held, base + el);
    end
    clock_ms = base + el + $urandom_range(0, 40);
    send_poll(!held, clock_ms);
  endtask

  task automatic test_reset_defaults();
    send_poll(1'b1, 32'd0);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b0, 32'd1050);
    send_poll(1'b0, 32'd1051);
    send_poll(1'b0, 32'd1501);
    send_poll(1'b0, 32'd1600);
    send_poll(1'b0, 32'd3001);
    send_poll(1'b0, 32'd11001);
    send_poll(1'b1, 32'd11002);
  endtask

  task automatic test_release_and_wrap();
    // bounce out of pre-click, then a press across the time wrap
    send_poll(1'b0, 32'hFFFF_FF00);
    send_poll(1'b1, 32'hFFFF_FF10);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0040);
    send_poll(1'b1, 32'h0000_0041);
    send_poll(1'b0, 32'd5000);
    send_poll(1'b0, 32'd7001);
    send_poll(1'b1, 32'd7002);
    send_poll(1'b0, 32'd9000);
    send_poll(1'b0, 32'd9600);
    send_poll(1'b1, 32'd9601);
  endtask

  task automatic test_threshold_extremes();
    cfg_t s;
    s = '{1'b0, '0, '0, '0, '0};
    apply_settings(s);
    send_poll(1'b1, 32'h1234_5678);
    send_poll(1'b1, 32'h1234_5679);
    send_poll(1'b0, 32'h1234_567A);
    s = '{1'b1, '1, '1, '1, '1};
    apply_settings(s);
    send_poll(1'b0, 32'd7);
    send_poll(1'b0, 32'd6);
    send_poll(1'b1, 32'd8);
  endtask

  task automatic test_backpressure();
    int unsigned mark;
    cfg_t        s;
    s = '{1'b1, 32'd3, 32'd10, 32'd20, 32'd40};
    apply_settings(s);
    mark = polls_sent;
    hold_off_left = 300;
    while (polls_sent - mark < 40) run_gesture();
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned start_mark;
    int unsigned phase_mark;
    int unsigned phase;
    start_mark = polls_sent;
    phase = 0;
    while (polls_sent - start_mark < 1650) begin
      apply_settings(random_settings());
      // one phase runs with no idling on either side
      in_gaps = (phase != 3);
      out_gaps = (phase != 3);
      phase_mark = polls_sent;
      while (polls_sent - phase_mark < 200 && polls_sent - start_mark < 1650) begin
        if ($urandom_range(99) < 12) send_poll(1'($urandom_range(1)), $urandom);
        else run_gesture();
      end
      phase++;
    end
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.pin_level = 1'b1;
    in_if.now_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ACTIVE_LOW;
    cfg_if.data = '0;
    shadow_cfg = '{1'b1, RST_DEBOUNCE_MS, RST_HOLD_MS, RST_LONG_HOLD_MS, RST_IDLE_MS};
    shadow_press = '{MODE_IDLE, '0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_release_and_wrap();
    test_threshold_extremes();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d polls under %0d register settings, %0d results checked",
             polls_sent, settings_applied, results_checked);
    $display("long holds begun %0d times, releases out of forced idle %0d times",
             long_holds_begun, forced_releases);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_in_if.sv
hw/rtl/bpc_out_if.sv
hw/rtl/bpc_cfg_if.sv
hw/rtl/bpc_step.sv
hw/rtl/bpc_cfg_regs.sv
hw/rtl/bpc_datapath.sv
hw/rtl/button_press_classifier.sv
sim/testbench.sv
